FILE: sv/ffcd_pkg.sv
// ---------------------------------------------------------------------------
// ffcd_pkg
// Shared widths, offsets, codes and types for the fixed-frame CRC deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package ffcd_pkg;

   // Frame geometry
   localparam int FRAME_LEN   = 26;
   localparam int FILL_W      = $clog2(FRAME_LEN + 1);
   localparam int IDX_W       = $clog2(FRAME_LEN);
   localparam int OFF_SEQ     = 2;
   localparam int OFF_ID      = 5;
   localparam int OFF_PAYLOAD = 8;
   localparam int OFF_CRC     = FRAME_LEN - 2;
   localparam int CRC_FIRST   = 1;
   localparam int CRC_LAST    = OFF_CRC - 1;

   // Field widths
   localparam int BYTE_W      = 8;
   localparam int MSG_ID_W    = 24;
   localparam int PAYLOAD_W   = 64;
   localparam int CNT_W       = 32;
   localparam int CRC_W       = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 24;

   // CRC-16/MCRF4XX
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

   // Register reset values
   localparam logic [BYTE_W-1:0]   SOF_RESET    = 8'hAA;
   localparam logic [MSG_ID_W-1:0] MSG_ID_RESET = 24'hC5CEC2;

   // Request action codes
   localparam logic ACT_DATA   = 1'b0;
   localparam logic ACT_RESYNC = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CRC_W-1:0]  crc_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOF_VALUE      = 1'b0,
      CSR_POSITION_MSGID = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CRC,
      ST_CHECK,
      ST_RESP
   } fsm_state_type;

   // Control into the shared CRC unit
   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

endpackage

`default_nettype wire

FILE: sv/ffcd_req_if.sv
// ---------------------------------------------------------------------------
// ffcd_req_if
// Request channel: one received byte or a resync action per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffcd_req_if
   import ffcd_pkg::*;
   ;
   logic     valid;
   logic     ready;
   logic     action;
   byte_type data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/ffcd_rsp_if.sv
// ---------------------------------------------------------------------------
// ffcd_rsp_if
// Response channel: frame hit, payload and status counters.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffcd_rsp_if
   import ffcd_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic                 position_frame;
   byte_type             frame_seq;
   logic [PAYLOAD_W-1:0] payload_low;
   logic [PAYLOAD_W-1:0] payload_high;
   cnt_type              bad_frame_count;
   cnt_type              crc_error_count;
   cnt_type              good_frame_count;
   cnt_type              seq_drop_count;
   cnt_type              byte_count;

   modport source (output valid, output position_frame, output frame_seq,
                   output payload_low, output payload_high,
                   output bad_frame_count, output crc_error_count,
                   output good_frame_count, output seq_drop_count,
                   output byte_count, input ready);
   modport sink   (input valid, input position_frame, input frame_seq,
                   input payload_low, input payload_high,
                   input bad_frame_count, input crc_error_count,
                   input good_frame_count, input seq_drop_count,
                   input byte_count, output ready);
endinterface

`default_nettype wire

FILE: sv/ffcd_csr_if.sv
// ---------------------------------------------------------------------------
// ffcd_csr_if
// Register write channel: index and data.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffcd_csr_if
   import ffcd_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/fixed_frame_crc_deframer_unit.sv
// ---------------------------------------------------------------------------
// fixed_frame_crc_deframer_unit
// Byte-stream deframer: SOF resync, CRC-16/MCRF4XX check, sequence tracking.
// ---------------------------------------------------------------------------
//
//  channel  dir  carries                                   handshake
//  -------  ---  ----------------------------------------  ---------------
//  req_ch   in   action, data_byte                         valid/ready
//  rsp_ch   out  frame hit, seq, payload, five counters    valid/ready
//  csr_ch   in   index (0 = SOF value, 1 = message id)     valid/ready
//
//  Steps: a byte that does not complete a window is accepted, scanned and
//  answered, with one scan step per byte dropped while hunting for SOF. A
//  full window adds a byte-serial CRC pass (23 bytes through the shared
//  CRC unit, then a compare); a CRC failure drops one byte and rescans,
//  and the window is then one byte short, so one request never runs a
//  second pass. A resync request goes from accept straight to respond.
//  Reset clears the control state and counters; the window needs none.
//  req_ch.ready is high only in idle; a response waiting in the output
//  register does not block the next request.
//
`default_nettype none

module fixed_frame_crc_deframer_unit
   import ffcd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ffcd_req_if.sink   req_ch,
   ffcd_rsp_if.source rsp_ch,
   ffcd_csr_if.sink   csr_ch
);

   // -----------------------------------------------------------------
   // Saturating counter helpers
   // -----------------------------------------------------------------
   function automatic cnt_type sat_inc(cnt_type c);
      return (c == '1) ? c : c + cnt_type'(1);
   endfunction

   function automatic cnt_type sat_add_byte(cnt_type c, byte_type b);
      logic [CNT_W:0] s;
      s = {1'b0, c} + {{(CNT_W+1-BYTE_W){1'b0}}, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   // -----------------------------------------------------------------
   // State
   // -----------------------------------------------------------------
   fsm_state_type         state_ff, state_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [IDX_W-1:0]      crc_idx_ff, crc_idx_in;
   logic                  bad_pend_ff, bad_pend_in;
   logic                  hit_ff, hit_in;
   byte_type              prev_seq_ff, prev_seq_in;
   logic                  known_ff, known_in;
   cnt_type               bad_ff, bad_in;
   cnt_type               crc_err_ff, crc_err_in;
   cnt_type               good_ff, good_in;
   cnt_type               drops_ff, drops_in;
   cnt_type               bytes_ff, bytes_in;
   byte_type              sof_ff;
   logic [MSG_ID_W-1:0]   msg_id_ff;

   // Frame window: written at the fill point, shifted down on a drop.
   byte_type              window_ff [FRAME_LEN];
   logic                  win_wr;
   logic                  win_shift;

   crc_ctl_type           crc_ctl;
   crc_type               crc_calc;
   crc_type               crc_rx;
   byte_type              seq_byte;
   byte_type              seq_expected;
   logic [MSG_ID_W-1:0]   frame_id;

   logic                  out_load;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   byte_type              rsp_seq_ff;
   logic [PAYLOAD_W-1:0]  rsp_plo_ff;
   logic [PAYLOAD_W-1:0]  rsp_phi_ff;
   cnt_type               rsp_bad_ff, rsp_crc_ff, rsp_good_ff, rsp_drops_ff, rsp_bytes_ff;
   logic [PAYLOAD_W-1:0]  pack_lo;
   logic [PAYLOAD_W-1:0]  pack_hi;

   // -----------------------------------------------------------------
   // Shared CRC unit, fed one window byte per cycle
   // -----------------------------------------------------------------
   ffcd_crc_unit u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .data  (window_ff[crc_idx_ff]),
      .crc   (crc_calc)
   );

   // Fixed-place window fields
   assign crc_rx       = {window_ff[OFF_CRC + 1], window_ff[OFF_CRC]};
   assign seq_byte     = window_ff[OFF_SEQ];
   assign seq_expected = prev_seq_ff + byte_type'(1);
   assign frame_id     = {window_ff[OFF_ID], window_ff[OFF_ID + 1], window_ff[OFF_ID + 2]};

   always_comb begin
      for (int i = 0; i < PAYLOAD_W / BYTE_W; i++) begin
         pack_lo[i*BYTE_W +: BYTE_W] = window_ff[OFF_PAYLOAD + i];
         pack_hi[i*BYTE_W +: BYTE_W] = window_ff[OFF_PAYLOAD + PAYLOAD_W / BYTE_W + i];
      end
   end

   // -----------------------------------------------------------------
   // Sequencer
   // -----------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      crc_idx_in  = crc_idx_ff;
      bad_pend_in = bad_pend_ff;
      hit_in      = hit_ff;
      prev_seq_in = prev_seq_ff;
      known_in    = known_ff;
      bad_in      = bad_ff;
      crc_err_in  = crc_err_ff;
      good_in     = good_ff;
      drops_in    = drops_ff;
      bytes_in    = bytes_ff;
      win_wr      = 1'b0;
      win_shift   = 1'b0;
      crc_ctl     = '0;
      out_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               hit_in      = 1'b0;
               bad_pend_in = 1'b0;
               if (req_ch.action == ACT_RESYNC) begin
                  fill_in     = '0;
                  prev_seq_in = '0;
                  known_in    = 1'b0;
                  state_in    = ST_RESP;
               end else begin
                  bytes_in = sat_inc(bytes_ff);
                  if (fill_ff < FILL_W'(FRAME_LEN)) begin
                     win_wr  = 1'b1;
                     fill_in = fill_ff + FILL_W'(1);
                  end
                  state_in = ST_SCAN;
               end
            end
         end

         // Drop bytes one at a time until the front holds SOF; the whole
         // realignment counts as one bad frame.
         ST_SCAN: begin
            if (fill_ff == '0) begin
               if (bad_pend_ff) bad_in = sat_inc(bad_ff);
               bad_pend_in = 1'b0;
               state_in    = ST_RESP;
            end else if (window_ff[0] != sof_ff) begin
               bad_pend_in = 1'b1;
               win_shift   = 1'b1;
               fill_in     = fill_ff - FILL_W'(1);
            end else begin
               if (bad_pend_ff) bad_in = sat_inc(bad_ff);
               bad_pend_in = 1'b0;
               if (fill_ff < FILL_W'(FRAME_LEN)) begin
                  state_in = ST_RESP;
               end else begin
                  crc_ctl.init = 1'b1;
                  crc_idx_in   = IDX_W'(CRC_FIRST);
                  state_in     = ST_CRC;
               end
            end
         end

         ST_CRC: begin
            crc_ctl.step = 1'b1;
            crc_idx_in   = crc_idx_ff + IDX_W'(1);
            if (crc_idx_ff == IDX_W'(CRC_LAST)) state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (crc_calc != crc_rx) begin
               // Mismatch: slip one byte and hunt again
               crc_err_in = sat_inc(crc_err_ff);
               win_shift  = 1'b1;
               fill_in    = fill_ff - FILL_W'(1);
               state_in   = ST_SCAN;
            end else begin
               good_in = sat_inc(good_ff);
               if (known_ff && (seq_byte != seq_expected)) begin
                  drops_in = sat_add_byte(drops_ff, seq_byte - seq_expected);
               end
               prev_seq_in = seq_byte;
               known_in    = 1'b1;
               hit_in      = (frame_id == msg_id_ff);
               fill_in     = '0;
               state_in    = ST_RESP;
            end
         end

         // Window is untouched here, so the payload is read straight from it.
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         crc_idx_ff  <= '0;
         bad_pend_ff <= 1'b0;
         hit_ff      <= 1'b0;
         prev_seq_ff <= '0;
         known_ff    <= 1'b0;
         bad_ff      <= '0;
         crc_err_ff  <= '0;
         good_ff     <= '0;
         drops_ff    <= '0;
         bytes_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         crc_idx_ff  <= crc_idx_in;
         bad_pend_ff <= bad_pend_in;
         hit_ff      <= hit_in;
         prev_seq_ff <= prev_seq_in;
         known_ff    <= known_in;
         bad_ff      <= bad_in;
         crc_err_ff  <= crc_err_in;
         good_ff     <= good_in;
         drops_ff    <= drops_in;
         bytes_ff    <= bytes_in;
      end
   end

   // Window storage
   always_ff @(posedge clock) begin
      if (win_wr) begin
         window_ff[fill_ff[IDX_W-1:0]] <= req_ch.data_byte;
      end else if (win_shift) begin
         for (int i = 0; i < FRAME_LEN - 1; i++) begin
            window_ff[i] <= window_ff[i + 1];
         end
      end
   end

   // -----------------------------------------------------------------
   // Configuration registers
   // -----------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sof_ff    <= SOF_RESET;
         msg_id_ff <= MSG_ID_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_SOF_VALUE:      sof_ff    <= csr_ch.data[BYTE_W-1:0];
            CSR_POSITION_MSGID: msg_id_ff <= csr_ch.data[MSG_ID_W-1:0];
            default: ;
         endcase
      end
   end

   // -----------------------------------------------------------------
   // Request / response handshakes
   // -----------------------------------------------------------------
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)          rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // Output register; frame fields read zero when the response carries no hit
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_hit_ff   <= hit_ff;
         rsp_seq_ff   <= hit_ff ? seq_byte : '0;
         rsp_plo_ff   <= hit_ff ? pack_lo : '0;
         rsp_phi_ff   <= hit_ff ? pack_hi : '0;
         rsp_bad_ff   <= bad_ff;
         rsp_crc_ff   <= crc_err_ff;
         rsp_good_ff  <= good_ff;
         rsp_drops_ff <= drops_ff;
         rsp_bytes_ff <= bytes_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.position_frame   = rsp_hit_ff;
   assign rsp_ch.frame_seq        = rsp_seq_ff;
   assign rsp_ch.payload_low      = rsp_plo_ff;
   assign rsp_ch.payload_high     = rsp_phi_ff;
   assign rsp_ch.bad_frame_count  = rsp_bad_ff;
   assign rsp_ch.crc_error_count  = rsp_crc_ff;
   assign rsp_ch.good_frame_count = rsp_good_ff;
   assign rsp_ch.seq_drop_count   = rsp_drops_ff;
   assign rsp_ch.byte_count       = rsp_bytes_ff;

endmodule

`default_nettype wire

FILE: sv/ffcd_crc_unit.sv
// ---------------------------------------------------------------------------
// ffcd_crc_unit
// CRC-16/MCRF4XX accumulator, one byte per step.
// ---------------------------------------------------------------------------
`default_nettype none

module ffcd_crc_unit
   import ffcd_pkg::*;
(
   input  wire logic        clock,
   input  wire crc_ctl_type ctl,
   input  wire byte_type    data,
   output crc_type          crc
);

   crc_type crc_ff;
   crc_type crc_in;

   // Reflected polynomial, LSB first, eight bit steps.
   function automatic crc_type crc_byte_step(crc_type c, byte_type b);
      crc_type r;
      r = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (r[0]) r = (r >> 1) ^ CRC_POLY;
         else      r = r >> 1;
      end
      return r;
   endfunction

   always_comb begin
      crc_in = crc_ff;
      if (ctl.init)      crc_in = CRC_INIT;
      else if (ctl.step) crc_in = crc_byte_step(crc_ff, data);
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire
